// ----- src/assert_macros.svh -----
// assertion macros used by the color fader controller
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define RCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define RCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rcf_pkg.sv -----
// shared types and constants of the rgb color fader
// used by every module of the block, no dependencies
package rcf_pkg;

  localparam int unsigned NumKeys     = 6;
  localparam int unsigned KeyW        = 24;
  localparam int unsigned StepW       = 16;
  localparam int unsigned SegW        = 3;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned FracBitsDef = 16;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // stream widths
  localparam int unsigned SDataW = 8;
  localparam int unsigned MDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegKey0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey5   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSteps  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegEnable = 3'd7;

  // last segment index
  localparam logic [SegW-1:0] LastSeg = SegW'(NumKeys - 1);

  typedef logic [NumKeys-1:0][KeyW-1:0] key_arr_t;

  localparam key_arr_t KeyReset = {24'hFF0000, 24'h00FF00, 24'h0000FF,
                                   24'hFF0000, 24'h00FF00, 24'h0000FF};
  localparam logic [StepW-1:0] StepsReset  = 16'd500;
  localparam logic             EnableReset = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // tick taken with the fade running
    logic load_next;  // read next key, set up dividers
    logic div_step;   // one quotient bit per lane
    logic sign_fix;   // apply sign to quotient, store delta
    logic add;        // accumulate and advance counters
    logic emit;       // load output register
    logic blank;      // emit black, fade disabled
  } rcf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic seg_start;  // this tick opens a segment
  } rcf_sts_t;

endpackage

// ----- src/rcf_cfg.sv -----
// configuration registers of the color fader
// depends on rcf_pkg
module rcf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rcf_pkg::CfgDataW-1:0]    cfg_data_i,
  output rcf_pkg::key_arr_t               keys_o,
  output logic [rcf_pkg::StepW-1:0]       steps_o,
  output logic                            enable_o
);

  rcf_pkg::key_arr_t               keys_q;
  logic [rcf_pkg::StepW-1:0]       steps_q;
  logic                            enable_q;

  assign cfg_ready_o = 1'b1;

  // register writes, one beat per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q   <= rcf_pkg::KeyReset;
      steps_q  <= rcf_pkg::StepsReset;
      enable_q <= rcf_pkg::EnableReset;
    end else if (cfg_valid_i) begin
      priority if (cfg_index_i == rcf_pkg::RegSteps) begin
        steps_q <= cfg_data_i[rcf_pkg::StepW-1:0];
      end else if (cfg_index_i == rcf_pkg::RegEnable) begin
        enable_q <= cfg_data_i[0];
      end else if (cfg_index_i >= rcf_pkg::RegKey0 && cfg_index_i <= rcf_pkg::RegKey5) begin
        keys_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  assign keys_o   = keys_q;
  assign steps_o  = steps_q;
  assign enable_o = enable_q;

endmodule

// ----- src/rcf_datapath.sv -----
// datapath of the color fader: counters, three accumulator lanes with
// bit-serial delta dividers, clamp and output register; depends on rcf_pkg
module rcf_datapath #(
  parameter int unsigned FracBits = rcf_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rcf_pkg::rcf_cmd_t              cmd_i,
  output rcf_pkg::rcf_sts_t              sts_o,
  input  logic                           restart_i,
  input  rcf_pkg::key_arr_t              keys_i,
  input  logic [rcf_pkg::StepW-1:0]      steps_i,
  output logic [rcf_pkg::ChanW-1:0]      red_o,
  output logic [rcf_pkg::ChanW-1:0]      green_o,
  output logic [rcf_pkg::ChanW-1:0]      blue_o,
  output logic [rcf_pkg::SegW-1:0]       segment_o,
  output logic                           cycle_end_o
);

  localparam int unsigned ChanW  = rcf_pkg::ChanW;
  localparam int unsigned StepW  = rcf_pkg::StepW;
  localparam int unsigned SegW   = rcf_pkg::SegW;
  localparam int unsigned QuoW   = FracBits + ChanW;
  localparam int unsigned DeltaW = QuoW + 1;
  // room for a full segment of 65535 ticks overshooting past the target
  localparam int unsigned AccW   = FracBits + ChanW + StepW + 2;

  logic [SegW-1:0]          seg_q;
  logic [StepW-1:0]         step_q;
  logic [SegW-1:0]          res_seg_q;
  logic                     res_end_q;
  logic [SegW-1:0]          seg_out_q;
  logic                     end_out_q;
  logic [2:0][ChanW-1:0]    pix_q;
  logic [2:0][ChanW-1:0]    pix_clamp;
  logic [StepW-1:0]         steps_eff;
  logic [SegW-1:0]          seg_eff;
  logic [SegW-1:0]          seg_nxt;
  logic [SegW-1:0]          rd_idx;
  logic [rcf_pkg::KeyW-1:0] key_rd;
  logic                     last;

  // a step count of zero acts as one
  assign steps_eff = (steps_i == '0) ? StepW'(1) : steps_i;

  assign seg_eff = restart_i ? '0 : seg_q;
  assign seg_nxt = (seg_q == rcf_pkg::LastSeg) ? '0 : seg_q + SegW'(1);

  // single key read port: current key at accept, next key after
  assign rd_idx = cmd_i.load_next ? seg_nxt : seg_eff;
  assign key_rd = keys_i[rd_idx];

  assign sts_o.seg_start = restart_i || (step_q == '0);

  assign last = ({1'b0, step_q} + (StepW+1)'(1)) >= {1'b0, steps_eff};

  // segment and tick counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.accept && restart_i) begin
      seg_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.add) begin
      if (last) begin
        step_q <= '0;
        seg_q  <= seg_nxt;
      end else begin
        step_q <= step_q + StepW'(1);
      end
    end
  end

  // per-tick side results held until the output register frees up
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      res_seg_q <= seg_q;
      res_end_q <= last && (seg_q == rcf_pkg::LastSeg);
    end
  end

  // red, green, blue lanes
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [ChanW-1:0]         chan;
    logic [ChanW-1:0]         cur;
    logic signed [ChanW:0]    diff;
    logic signed [ChanW:0]    diff_neg;
    logic [ChanW-1:0]         mag;
    logic signed [AccW-1:0]   acc_q;
    logic signed [DeltaW-1:0] delta_q;
    logic signed [DeltaW-1:0] quo_ext;
    logic [StepW-1:0]         rem_q;
    logic [QuoW-1:0]          quo_q;
    logic                     neg_q;
    logic [StepW:0]           trial;
    logic [StepW:0]           dvsr;
    logic                     ge;
    logic [StepW-1:0]         rem_d;
    logic [ChanW-1:0]         clamp;

    assign chan = key_rd[(2-c)*ChanW +: ChanW];
    assign cur  = acc_q[FracBits +: ChanW];

    // color difference, magnitude goes to the divider
    assign diff     = $signed({1'b0, chan}) - $signed({1'b0, cur});
    assign diff_neg = -diff;
    assign mag      = diff[ChanW] ? diff_neg[ChanW-1:0] : diff[ChanW-1:0];

    // restoring division, one quotient bit per cycle
    assign trial = {rem_q, quo_q[QuoW-1]};
    assign dvsr  = {1'b0, steps_eff};
    assign ge    = trial >= dvsr;
    assign rem_d = ge ? StepW'(trial - dvsr) : trial[StepW-1:0];

    assign quo_ext = $signed({1'b0, quo_q});

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept && sts_o.seg_start) begin
        acc_q <= AccW'({chan, {FracBits{1'b0}}});
      end else if (cmd_i.add) begin
        acc_q <= acc_q + AccW'(delta_q);
      end
      if (cmd_i.load_next) begin
        neg_q <= diff[ChanW];
        quo_q <= {mag, {FracBits{1'b0}}};
        rem_q <= '0;
      end else if (cmd_i.div_step) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[QuoW-2:0], ge};
      end
      if (cmd_i.sign_fix) begin
        delta_q <= neg_q ? -quo_ext : quo_ext;
      end
    end

    // integer part clamped to the channel range
    always_comb begin
      if (acc_q[AccW-1]) begin
        clamp = '0;
      end else if (|acc_q[AccW-2:FracBits+ChanW]) begin
        clamp = '1;
      end else begin
        clamp = acc_q[FracBits +: ChanW];
      end
    end

    assign pix_clamp[c] = clamp;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pix_q     <= cmd_i.blank ? '0 : pix_clamp;
      seg_out_q <= cmd_i.blank ? seg_q : res_seg_q;
      end_out_q <= !cmd_i.blank && res_end_q;
    end
  end

  assign red_o       = pix_q[0];
  assign green_o     = pix_q[1];
  assign blue_o      = pix_q[2];
  assign segment_o   = seg_out_q;
  assign cycle_end_o = end_out_q;

endmodule

// ----- src/rcf_ctrl.sv -----
// controller of the color fader: sequences accept, divide, accumulate
// and output; depends on rcf_pkg and assert_macros.svh
`include "assert_macros.svh"

module rcf_ctrl #(
  parameter int unsigned FracBits = rcf_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              enable_i,
  input  rcf_pkg::rcf_sts_t sts_i,
  output rcf_pkg::rcf_cmd_t cmd_o
);

  localparam int unsigned QuoW = FracBits + rcf_pkg::ChanW;
  localparam int unsigned CntW = $clog2(QuoW);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoadN = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StSign  = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            blank_q, blank_d;
  logic            m_valid_q, m_valid_d;
  logic            in_fire;
  logic            out_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !m_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    blank_d = blank_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (!enable_i) begin
            blank_d = 1'b1;
            state_d = StEmit;
          end else begin
            blank_d      = 1'b0;
            cmd_o.accept = 1'b1;
            state_d      = sts_i.seg_start ? StLoadN : StAdd;
          end
        end
      end
      StLoadN: begin
        cmd_o.load_next = 1'b1;
        cnt_d           = CntW'(QuoW - 1);
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = StSign;
        end
      end
      StSign: begin
        cmd_o.sign_fix = 1'b1;
        state_d        = StAdd;
      end
      StAdd: begin
        cmd_o.add = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.blank = blank_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output beat valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.emit) begin
      m_valid_d = 1'b1;
    end else if (out_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      blank_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      blank_q   <= blank_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign out_valid_o = m_valid_q;

  `RCF_ASSERT(a_cmd_onehot, $onehot0({cmd_o.accept, cmd_o.load_next, cmd_o.div_step, cmd_o.sign_fix, cmd_o.add, cmd_o.emit}), "more than one datapath command")
  `RCF_ASSERT_NEXT(a_fire_leaves_idle, in_fire, state_q != StIdle, "accepted beat did not start work")
  `RCF_ASSERT_NEXT(a_div_ends, state_q == StDiv && cnt_q == '0, state_q == StSign, "divider did not finish")
  `RCF_ASSERT_NEXT(a_emit_waits, state_q == StEmit && !out_free, state_q == StEmit && m_valid_q, "result dropped while output full")

endmodule

// ----- src/rgb_color_flow_fader.sv -----
// Cyclic RGB color fader through six key colors.
//
// Input stream: one beat per tick, tdata bit 0 is restart (back to segment 0).
// Output stream: one beat per tick with the current red, green and blue,
// the segment index, and tlast set on the last tick of the last segment.
// Configuration channel: index 0..5 key colors 0xRRGGBB, 6 ticks per
// segment, 7 fade enable; the user writes it only while no tick is in flight, the block does not enforce this.
// Flow: a tick inside a segment passes from accept through the add and emit
// states to the output register; a tick that opens a segment first loads the
// next key and runs the bit-serial delta divider, one quotient bit a cycle,
// three channels in parallel, then the sign fix. Ticks are handled one at a time.
// With the fade disabled an accepted tick goes straight to the emit state as a black beat.
// Reset loads the default key colors, 500 ticks per segment, enable on,
// and starts at segment 0. The output register holds a stalled beat; one
// new tick may be accepted and worked on meanwhile, and then waits until
// the receiver takes the held beat.
// Depends on rcf_pkg, rcf_cfg, rcf_ctrl and rcf_datapath.
module rgb_color_flow_fader #(
  parameter int unsigned FracBits = rcf_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rcf_pkg::SDataW-1:0]    s_axis_tdata,  // [0] restart, [7:1] zero
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rcf_pkg::MDataW-1:0]    m_axis_tdata,  // [7:0] red, [15:8] green,
                                                       // [23:16] blue, [26:24] segment,
                                                       // [31:27] zero
  output logic                          m_axis_tlast,  // cycle end
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcf_pkg::CfgDataW-1:0]  cfg_data_i
);

  rcf_pkg::key_arr_t               keys;
  logic [rcf_pkg::StepW-1:0]       steps;
  logic                            enable;
  rcf_pkg::rcf_cmd_t               cmd;
  rcf_pkg::rcf_sts_t               sts;
  logic [rcf_pkg::ChanW-1:0]       red;
  logic [rcf_pkg::ChanW-1:0]       green;
  logic [rcf_pkg::ChanW-1:0]       blue;
  logic [rcf_pkg::SegW-1:0]        segment;

  rcf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .keys_o      (keys),
    .steps_o     (steps),
    .enable_o    (enable)
  );

  rcf_ctrl #(
    .FracBits (FracBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .enable_i    (enable),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rcf_datapath #(
    .FracBits (FracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .restart_i   (s_axis_tdata[0]),
    .keys_i      (keys),
    .steps_i     (steps),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue),
    .segment_o   (segment),
    .cycle_end_o (m_axis_tlast)
  );

  // pack the output beat
  assign m_axis_tdata = {5'b0, segment, blue, green, red};

endmodule
